>>> src/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared constants and types for the positional list
// Sizes, request codes and the control word broadcast to the cell row.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             get;
        logic [IDX_W-1:0] idx;
    } cell_ctrl_t;

endpackage

>>> src/plc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_if: request and response channels
// Valid/ready channels carrying the list request and its result.
// ----------------------------------------------------------------------------
interface plc_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             req_type;
    logic [plc_pkg::POS_W-1:0]              position;
    logic signed [plc_pkg::DATA_W-1:0]      new_value;

    modport source (output valid, output req_type, output position, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input new_value,
                    output ready);
endinterface

interface plc_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   status;
    logic signed [plc_pkg::DATA_W-1:0]      read_value;
    logic [plc_pkg::CNT_W-1:0]              count_after;

    modport source (output valid, output status, output read_value, output count_after,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count_after,
                    output ready);
endinterface

>>> src/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with positional insert/delete
// Row of slot cells that shift all entries in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   req: request channel (req_type, position, new_value). Insert at
//        1..count+1, delete or get at 1..count; anything else, or an insert
//        when full, is an error with no change.
//   rsp: one response per request (status, read_value, count_after).
//   Throughput: one request per cycle while rsp is taken. The slot row
//   updates in the accept cycle; the get read-out passes a registered OR tree
//   (group stage, then output register), so requests pipeline back to back.
//   Reset: count goes to zero, both pipeline stages empty. Entry storage is
//   not cleared; only entries below the count are ever read.
//   Stall: while rsp is held, one request may sit in the group stage; then
//   req.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
(
    input  logic       clk,
    input  logic       rst_n,
    plc_req_if.sink    req,
    plc_rsp_if.source  rsp
);

    logic [plc_pkg::CNT_W-1:0]  count_reg;
    logic [plc_pkg::CNT_W-1:0]  count_next;

    logic [plc_pkg::CMP_W-1:0]  pos_ext;
    logic [plc_pkg::CMP_W-1:0]  cnt_ext;
    logic                       pos_nz;
    logic                       accept;
    logic                       ins_ok;
    logic                       del_ok;
    logic                       get_ok;
    plc_pkg::cell_ctrl_t        ctrl;

    logic [plc_pkg::DATA_W-1:0] cell_value [plc_pkg::CAPACITY];
    logic [plc_pkg::DATA_W-1:0] cell_rd    [plc_pkg::CAPACITY];
    logic [plc_pkg::DATA_W-1:0] grp_next   [plc_pkg::NGROUP];

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_status_reg;
    logic [plc_pkg::CNT_W-1:0]  s1_count_reg;
    logic [plc_pkg::DATA_W-1:0] s1_grp_reg [plc_pkg::NGROUP];
    logic                       s1_adv;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_status_reg;
    logic [plc_pkg::CNT_W-1:0]  out_count_reg;
    logic [plc_pkg::DATA_W-1:0] out_read_reg;
    logic [plc_pkg::DATA_W-1:0] out_read_next;

    // request decode
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign pos_ext = plc_pkg::CMP_W'(req.position);
    assign cnt_ext = plc_pkg::CMP_W'(count_reg);
    assign pos_nz  = (req.position != '0);

    assign ins_ok = accept && (req.req_type == plc_pkg::REQ_INSERT) && pos_nz
                    && (pos_ext <= cnt_ext + plc_pkg::CMP_W'(1))
                    && (cnt_ext < plc_pkg::CMP_W'(plc_pkg::CAPACITY));
    assign del_ok = accept && (req.req_type == plc_pkg::REQ_DELETE) && pos_nz
                    && (pos_ext <= cnt_ext);
    assign get_ok = accept && (req.req_type == plc_pkg::REQ_GET) && pos_nz
                    && (pos_ext <= cnt_ext);

    always_comb
    begin
        ctrl.ins = ins_ok;
        ctrl.del = del_ok;
        ctrl.get = get_ok;
        ctrl.idx = plc_pkg::IDX_W'(pos_ext - plc_pkg::CMP_W'(1));
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + plc_pkg::CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - plc_pkg::CNT_W'(1);
        end
    end

    // slot row
    for (genvar i = 0; i < plc_pkg::CAPACITY; i++)
    begin : g_cell
        logic [plc_pkg::DATA_W-1:0] left_value;
        logic [plc_pkg::DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_mid_l
            assign left_value = cell_value[i-1];
        end

        if (i == plc_pkg::CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_mid_r
            assign right_value = cell_value[i+1];
        end

        plc_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .slot        (plc_pkg::IDX_W'(i)),
            .left_value  (left_value),
            .right_value (right_value),
            .new_value   (plc_pkg::DATA_W'(req.new_value)),
            .value       (cell_value[i]),
            .rd_value    (cell_rd[i])
        );
    end

    // read-out tree, first level
    always_comb
    begin
        for (int g = 0; g < plc_pkg::NGROUP; g++)
        begin
            grp_next[g] = '0;
        end
        for (int i = 0; i < plc_pkg::CAPACITY; i++)
        begin
            grp_next[i / plc_pkg::GROUP] = grp_next[i / plc_pkg::GROUP] | cell_rd[i];
        end
    end

    // read-out tree, second level
    always_comb
    begin
        out_read_next = '0;
        for (int g = 0; g < plc_pkg::NGROUP; g++)
        begin
            out_read_next = out_read_next | s1_grp_reg[g];
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= (ins_ok || del_ok || get_ok) ? plc_pkg::STATUS_DONE
                                                          : plc_pkg::STATUS_ERROR;
            s1_count_reg  <= count_next;
            for (int g = 0; g < plc_pkg::NGROUP; g++)
            begin
                s1_grp_reg[g] <= grp_next[g];
            end
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
            out_read_reg   <= out_read_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_value  = signed'(out_read_reg);
    assign rsp.count_after = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plc_pkg::CNT_W'(plc_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + plc_pkg::CNT_W'(1))
        else $error("insert did not bump count");

    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        !ins_ok && !del_ok |=> $stable(count_reg))
        else $error("count changed without a valid insert or delete");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == plc_pkg::STATUS_ERROR) |-> out_read_reg == '0)
        else $error("error response with nonzero read value");
`endif

endmodule

>>> src/plc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_cell: one list slot
// Holds one entry; shifts from its left or right neighbor, loads a new value,
// or holds, and offers its entry on the read bus when addressed by a get.
// ----------------------------------------------------------------------------
module plc_cell
(
    input  logic                         clk,
    input  plc_pkg::cell_ctrl_t          ctrl,
    input  logic [plc_pkg::IDX_W-1:0]    slot,
    input  logic [plc_pkg::DATA_W-1:0]   left_value,
    input  logic [plc_pkg::DATA_W-1:0]   right_value,
    input  logic [plc_pkg::DATA_W-1:0]   new_value,
    output logic [plc_pkg::DATA_W-1:0]   value,
    output logic [plc_pkg::DATA_W-1:0]   rd_value
);

    logic [plc_pkg::DATA_W-1:0] value_reg;
    logic [plc_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (slot > ctrl.idx)
            begin
                value_next = left_value;
            end
            else if (slot == ctrl.idx)
            begin
                value_next = new_value;
            end
        end
        else if (ctrl.del)
        begin
            if (slot >= ctrl.idx)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    assign rd_value = (ctrl.get && (slot == ctrl.idx)) ? value_reg : '0;

endmodule
